[rtl/core/pqad_pkg.sv]
// Shared types, codes and constants of the PQ asymmetric distance block.
// Depends on nothing; every other file of the block but pqad_ram refers to it.
`timescale 1ns / 1ps

package pqad_pkg;

    // Sizing of the codebook and of the query walk
    localparam int MAX_SUBSPACES = 32;
    localparam int NUM_CENTERS   = 256;
    localparam int MAX_SUB_LEN   = 8;
    localparam int LEN_LIMIT     = (MAX_SUB_LEN < 8) ? MAX_SUB_LEN : 8;

    localparam int ADDR_W  = 16;
    localparam int CB_DEPTH = 65536;
    localparam int ELEM_W  = 16;
    localparam int ACC_W   = 48;
    localparam int POS_W   = 3;
    localparam int SUB_W   = 5;
    localparam int CODE_W  = 8;
    localparam int CFG_W   = 4;

    // Entries of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Integer root: one result bit per step
    localparam int ROOT_STEPS = 32;
    localparam int ROOT_CNT_W = 5;

    // 1.0 in Q16.16
    localparam logic signed [ACC_W:0] ONE_Q16 = 49'sd65536;

    // Operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DIST  = 1'b1;

    // Metric codes
    localparam logic [2:0] MET_DOT  = 3'd0;
    localparam logic [2:0] MET_COS  = 3'd1;
    localparam logic [2:0] MET_SQL2 = 3'd2;
    localparam logic [2:0] MET_L2   = 3'd3;
    localparam logic [2:0] MET_L1   = 3'd4;

    // Configuration register indexes
    localparam logic CFG_METRIC  = 1'b0;
    localparam logic CFG_SUB_LEN = 1'b1;

    // One classified item on its way from front to back
    typedef struct packed {
        logic                     op;
        logic [ADDR_W-1:0]        addr;
        logic signed [ELEM_W-1:0] data;
        logic                     last;
    } item_t;

endpackage

[rtl/core/pqad_ram.sv]
// Generic single-port RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pqad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write a word, or register the word read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/pqad_front.sv]
// Front end: accepts input beats, tracks subspace and element position,
// and forms the codebook address of each item. Depends on pqad_pkg.
`timescale 1ns / 1ps

module pqad_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [pqad_pkg::CFG_W-1:0]         sub_len,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [pqad_pkg::ADDR_W-1:0]        cb_address,
    input  logic signed [pqad_pkg::ELEM_W-1:0] cb_value,
    input  logic signed [pqad_pkg::ELEM_W-1:0] query_value,
    input  logic [pqad_pkg::CODE_W-1:0]        code,
    input  logic                               last,
    input  logic                               queue_full,
    output logic                               push,
    output pqad_pkg::item_t                    item
);

    logic [pqad_pkg::POS_W-1:0] pos_reg, pos_next;
    logic [pqad_pkg::SUB_W-1:0] sub_reg, sub_next;
    logic [pqad_pkg::CODE_W-1:0] code_clamped;
    logic [pqad_pkg::CFG_W-1:0]  eff_len;
    logic [pqad_pkg::CFG_W-1:0]  pos_inc;
    logic [8:0]                  sub_inc;

    assign in_ready = !queue_full;
    assign push     = in_valid && in_ready;

    // Clamp the center index and the subspace length
    always_comb
    begin
        if (32'(code) > pqad_pkg::NUM_CENTERS - 1)
        begin
            code_clamped = pqad_pkg::CODE_W'(pqad_pkg::NUM_CENTERS - 1);
        end
        else
        begin
            code_clamped = code;
        end
        if (sub_len == '0)
        begin
            eff_len = pqad_pkg::CFG_W'(1);
        end
        else if (32'(sub_len) > pqad_pkg::LEN_LIMIT)
        begin
            eff_len = pqad_pkg::CFG_W'(pqad_pkg::LEN_LIMIT);
        end
        else
        begin
            eff_len = sub_len;
        end
    end

    // Build the queue item
    always_comb
    begin
        item.op   = operation;
        item.last = last;
        if (operation == pqad_pkg::OP_WRITE)
        begin
            item.addr = cb_address;
            item.data = cb_value;
        end
        else
        begin
            item.addr = {sub_reg, code_clamped, pos_reg};
            item.data = query_value;
        end
    end

    // Advance position within subspace, wrap subspaces, restart on last
    always_comb
    begin
        pos_next = pos_reg;
        sub_next = sub_reg;
        pos_inc  = {1'b0, pos_reg} + pqad_pkg::CFG_W'(1);
        sub_inc  = {4'b0, sub_reg} + 9'd1;
        if (push && operation == pqad_pkg::OP_DIST)
        begin
            if (last)
            begin
                pos_next = '0;
                sub_next = '0;
            end
            else if (pos_inc >= eff_len)
            begin
                pos_next = '0;
                if (32'(sub_inc) >= pqad_pkg::MAX_SUBSPACES)
                begin
                    sub_next = '0;
                end
                else
                begin
                    sub_next = sub_inc[pqad_pkg::SUB_W-1:0];
                end
            end
            else
            begin
                pos_next = pos_inc[pqad_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            sub_reg <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            sub_reg <= sub_next;
        end
    end

endmodule

[rtl/core/pqad_queue.sv]
// Short FIFO of classified items between front and back.
// Depends on pqad_pkg.
`timescale 1ns / 1ps

module pqad_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  pqad_pkg::item_t push_item,
    input  logic            pop,
    output logic            head_valid,
    output pqad_pkg::item_t head_item,
    output logic            full
);

    localparam int DEPTH = pqad_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    pqad_pkg::item_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_item  = slot_reg[rd_ptr_reg];

    // Move pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (32'(wr_ptr_reg) == DEPTH - 1) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (32'(rd_ptr_reg) == DEPTH - 1) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/core/pqad_back.sv]
// Back end: codebook memory, multiply-accumulate, finishing step with an
// iterative integer root, and the output register. Depends on pqad_pkg, pqad_ram.
`timescale 1ns / 1ps

module pqad_back (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic [2:0]                         metric,
    input  logic                               head_valid,
    input  pqad_pkg::item_t                    head_item,
    output logic                               pop,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pqad_pkg::ACC_W-1:0]  distance,
    output logic                               saturated
);

    localparam int AW = pqad_pkg::ACC_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAC  = 3'd1;
    localparam logic [2:0] S_FIN  = 3'd2;
    localparam logic [2:0] S_ROOT = 3'd3;
    localparam logic [2:0] S_DONE = 3'd4;

    localparam logic signed [AW-1:0] ACC_MAX = {1'b0, {(AW-1){1'b1}}};
    localparam logic signed [AW-1:0] ACC_MIN = {1'b1, {(AW-1){1'b0}}};

    logic [2:0] state_reg, state_next;

    logic [2:0] met;
    logic       ram_we, ram_re;
    logic [pqad_pkg::ELEM_W-1:0] ram_rdata;

    logic signed [pqad_pkg::ELEM_W-1:0] q_reg;
    logic        last_reg;
    logic signed [AW-1:0] acc_reg, acc_next;
    logic        ov_reg, ov_next;

    logic signed [pqad_pkg::ELEM_W-1:0] cb_elem;
    logic signed [16:0] diff, mul_a, mul_b;
    logic signed [33:0] prod;
    logic [16:0]        abs_diff;
    logic signed [AW:0] term, sum, fin_wide;
    logic signed [AW-1:0] acc_sat, fin_sat;
    logic        sum_ovf, fin_ovf;

    logic [63:0] x_reg, x_next;
    logic [31:0] root_reg, root_next;
    logic [33:0] rem_reg, rem_next;
    logic [33:0] rem_sh, trial;
    logic [pqad_pkg::ROOT_CNT_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] acc_pos;

    logic signed [AW-1:0] result_reg, result_next;
    logic        rsat_reg, rsat_next;
    logic        out_valid_reg;
    logic signed [AW-1:0] distance_reg;
    logic        saturated_reg;
    logic        out_load;

    // Fold unknown metrics onto squared L2
    assign met = (metric > pqad_pkg::MET_L1) ? pqad_pkg::MET_SQL2 : metric;

    // Take a beat from the queue; writes and reads go to the memory in order
    assign pop    = (state_reg == S_IDLE) && head_valid;
    assign ram_we = pop && (head_item.op == pqad_pkg::OP_WRITE);
    assign ram_re = pop && (head_item.op == pqad_pkg::OP_DIST);

    pqad_ram #(
        .WIDTH (pqad_pkg::ELEM_W),
        .DEPTH (pqad_pkg::CB_DEPTH)
    ) u_codebook (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (head_item.addr),
        .wdata (head_item.data),
        .rdata (ram_rdata)
    );

    // Form the term of one element and add it with saturation
    always_comb
    begin
        cb_elem  = signed'(ram_rdata);
        diff     = 17'(q_reg) - 17'(cb_elem);
        abs_diff = diff[16] ? 17'(-diff) : 17'(diff);
        if (met == pqad_pkg::MET_DOT || met == pqad_pkg::MET_COS)
        begin
            mul_a = 17'(q_reg);
            mul_b = 17'(cb_elem);
        end
        else
        begin
            mul_a = diff;
            mul_b = diff;
        end
        prod = mul_a * mul_b;
        if (met == pqad_pkg::MET_L1)
        begin
            term = signed'({24'b0, abs_diff, 8'b0});
        end
        else
        begin
            term = (AW+1)'(prod);
        end
        sum     = {acc_reg[AW-1], acc_reg} + term;
        sum_ovf = (sum[AW] != sum[AW-1]);
        acc_sat = sum_ovf ? (sum[AW] ? ACC_MIN : ACC_MAX) : sum[AW-1:0];
    end

    // Finish dot and cosine with saturation
    always_comb
    begin
        if (met == pqad_pkg::MET_DOT)
        begin
            fin_wide = -{acc_reg[AW-1], acc_reg};
        end
        else
        begin
            fin_wide = pqad_pkg::ONE_Q16 - {acc_reg[AW-1], acc_reg};
        end
        fin_ovf = (fin_wide[AW] != fin_wide[AW-1]);
        fin_sat = fin_ovf ? (fin_wide[AW] ? ACC_MIN : ACC_MAX) : fin_wide[AW-1:0];
        acc_pos = acc_reg[AW-1] ? '0 : acc_reg;
    end

    // One step of the bitwise integer root
    always_comb
    begin
        rem_sh = {rem_reg[31:0], x_reg[63:62]};
        trial  = {root_reg, 2'b01};
    end

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    // Sequence one item through read, accumulate, finish and deliver
    always_comb
    begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        ov_next     = ov_reg;
        x_next      = x_reg;
        root_next   = root_reg;
        rem_next    = rem_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        rsat_next   = rsat_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (ram_re)
                begin
                    state_next = S_MAC;
                end
            end
            S_MAC:
            begin
                acc_next   = acc_sat;
                ov_next    = ov_reg || sum_ovf;
                state_next = last_reg ? S_FIN : S_IDLE;
            end
            S_FIN:
            begin
                if (met == pqad_pkg::MET_L2)
                begin
                    x_next     = {acc_pos, 16'b0};
                    root_next  = '0;
                    rem_next   = '0;
                    cnt_next   = '0;
                    state_next = S_ROOT;
                end
                else if (met == pqad_pkg::MET_DOT || met == pqad_pkg::MET_COS)
                begin
                    result_next = fin_sat;
                    rsat_next   = fin_ovf;
                    state_next  = S_DONE;
                end
                else
                begin
                    result_next = acc_reg;
                    rsat_next   = 1'b0;
                    state_next  = S_DONE;
                end
            end
            S_ROOT:
            begin
                x_next = {x_reg[61:0], 2'b00};
                if (rem_sh >= trial)
                begin
                    rem_next  = rem_sh - trial;
                    root_next = {root_reg[30:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_sh;
                    root_next = {root_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg + pqad_pkg::ROOT_CNT_W'(1);
                if (32'(cnt_reg) == pqad_pkg::ROOT_STEPS - 1)
                begin
                    result_next = signed'({16'b0, root_next});
                    rsat_next   = 1'b0;
                    state_next  = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    acc_next   = '0;
                    ov_next    = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_reg       <= '0;
            ov_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            acc_reg   <= acc_next;
            ov_reg    <= ov_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the element, root datapath and output payload
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            q_reg    <= head_item.data;
            last_reg <= head_item.last;
        end
        x_reg      <= x_next;
        root_reg   <= root_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
        rsat_reg   <= rsat_next;
        if (out_load)
        begin
            distance_reg  <= result_reg;
            saturated_reg <= ov_reg || rsat_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign distance  = distance_reg;
    assign saturated = saturated_reg;

    // Accumulate only right after a distance beat was read from memory
    a_mac_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_MAC) |-> $past(ram_re))
        else $error("accumulate step without a memory read");

    // Root remainder never exceeds twice the partial root
    a_root_rem: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROOT) |-> (rem_reg <= {1'b0, root_reg, 1'b0}))
        else $error("root remainder out of bound");

    // A new result appears only from the delivery state
    a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result raised outside delivery");

    // Delivery clears the running sum and flag for the next vector
    a_clear_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (acc_reg == '0) && !ov_reg)
        else $error("running state not cleared after delivery");

endmodule

[rtl/core/pq_asymmetric_distance_top.sv]
// Top level of the PQ asymmetric distance block: configuration registers,
// front end, item queue and back end. Depends on pqad_pkg and all pqad_* modules.
//
// Usage:
//   Input channel (in_valid/in_ready): a beat with operation 0 stores cb_value at
//   cb_address in the 64K-word codebook. A beat with operation 1 carries one
//   query element and the code of its subspace; the matching codebook element
//   is fetched and accumulated under the selected metric. last=1 ends a vector.
//   Output channel (out_valid/out_ready): one beat per vector with the Q16.16
//   distance and the saturation flag.
//   Configuration channel (cfg_valid/cfg_ready, always ready): index 0 metric,
//   index 1 sub_len; write only while the block is idle.
// Back end: each distance beat passes a memory read, then a multiply-accumulate,
//   before the next beat is taken; a codebook write needs only the memory step.
//   After the last element the result passes a finishing step, under L2 also the
//   integer root, which produces one bit per cycle, before the delivery state.
// Reset clears the running sum, positions, flag and queue, and sets metric 2,
//   sub_len 8; the codebook is not cleared. When the receiver stalls, the result
//   holds in the output register while the queue and front keep taking beats
//   until the queue fills.
`timescale 1ns / 1ps

module pq_asymmetric_distance_top (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [pqad_pkg::CFG_W-1:0]         cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic                               operation,
    input  logic [pqad_pkg::ADDR_W-1:0]        cb_address,
    input  logic signed [pqad_pkg::ELEM_W-1:0] cb_value,
    input  logic signed [pqad_pkg::ELEM_W-1:0] query_value,
    input  logic [pqad_pkg::CODE_W-1:0]        code,
    input  logic                               last,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [pqad_pkg::ACC_W-1:0]  distance,
    output logic                               saturated
);

    logic [2:0]                 metric_reg;
    logic [pqad_pkg::CFG_W-1:0] sub_len_reg;

    logic            push, pop, queue_full, head_valid;
    pqad_pkg::item_t push_item, head_item;

    assign cfg_ready = 1'b1;

    // Write the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_reg  <= pqad_pkg::MET_SQL2;
            sub_len_reg <= pqad_pkg::CFG_W'(8);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                pqad_pkg::CFG_METRIC:  metric_reg  <= cfg_data[2:0];
                pqad_pkg::CFG_SUB_LEN: sub_len_reg <= cfg_data;
                default:               metric_reg  <= metric_reg;
            endcase
        end
    end

    pqad_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .sub_len     (sub_len_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .cb_address  (cb_address),
        .cb_value    (cb_value),
        .query_value (query_value),
        .code        (code),
        .last        (last),
        .queue_full  (queue_full),
        .push        (push),
        .item        (push_item)
    );

    pqad_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item),
        .full       (queue_full)
    );

    pqad_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .metric     (metric_reg),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .distance   (distance),
        .saturated  (saturated)
    );

endmodule

[sim/pqad_distance_checker.sv]
// Distance checker for the PQ asymmetric distance block: tracks config and codebook
// beats, predicts each distance result and compares it with the output channel.
// Depends on pqad_pkg.
`timescale 1ns / 1ps

module pqad_distance_checker
    import pqad_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic                      cfg_index,
    input  logic [CFG_W-1:0]          cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      operation,
    input  logic [ADDR_W-1:0]         cb_address,
    input  logic signed [ELEM_W-1:0]  cb_value,
    input  logic signed [ELEM_W-1:0]  query_value,
    input  logic [CODE_W-1:0]         code,
    input  logic                      last,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic signed [ACC_W-1:0]   distance,
    input  logic                      saturated,
    output int                        mismatches,
    output int                        outstanding
);

    localparam longint SUM_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam int SUB_STRIDE = 2048;
    localparam int CTR_STRIDE = 8;
    localparam logic [CFG_W-1:0] SUB_LEN_RESET = 4'd8;

    typedef struct packed {
        logic signed [ACC_W-1:0] distance_val;
        logic                    sat;
    } dist_result_t;

    // Shadow of the block: codebook, registers and the running vector
    logic signed [ELEM_W-1:0] cb_words [CB_DEPTH];
    logic [2:0]               metric_q;
    logic [CFG_W-1:0]         sub_len_q;
    longint                   run_sum;
    logic [POS_W-1:0]         elem_pos;
    logic [SUB_W-1:0]         sub_idx;
    logic                     sum_clipped;
    dist_result_t             expected_distances [$];
    dist_result_t             oldest;

    // Clip to the signed 48-bit range and flag the clip
    function automatic longint clip48(input longint v, inout logic hit);
        if (v > SUM_MAX) begin
            hit = 1'b1;
            return SUM_MAX;
        end
        if (v < SUM_MIN) begin
            hit = 1'b1;
            return SUM_MIN;
        end
        return v;
    endfunction

    // Floor of the square root, settled one result bit at a time
    function automatic longint unsigned int_root(input longint unsigned radicand);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand)
                root = trial;
        end
        return root;
    endfunction

    // Fold one query element into the running sum; finish the vector on last
    function automatic void accumulate_element(input logic signed [ELEM_W-1:0] qv,
                                               input logic [CODE_W-1:0] cd,
                                               input logic lst);
        logic [2:0]        met;
        logic [CODE_W-1:0] ctr;
        logic [ADDR_W-1:0] addr;
        longint            qs;
        longint            cs;
        longint            diff;
        longint            term;
        longint            fin;
        logic              fin_clip;
        int                len;
        dist_result_t      res;

        met = (metric_q > MET_L1) ? MET_SQL2 : metric_q;
        ctr = cd;
        if (int'(cd) > NUM_CENTERS - 1)
            ctr = CODE_W'(NUM_CENTERS - 1);
        addr = ADDR_W'(int'(sub_idx) * SUB_STRIDE + int'(ctr) * CTR_STRIDE + int'(elem_pos));
        qs = longint'(qv);
        cs = longint'(cb_words[addr]);
        diff = qs - cs;

        case (met)
            MET_DOT, MET_COS: term = qs * cs;
            MET_L1:           term = ((diff < 0) ? -diff : diff) * 256;
            default:          term = diff * diff;
        endcase
        run_sum = clip48(run_sum + term, sum_clipped);

        // Advance the element walk; a position past the length ends the subspace
        len = int'(sub_len_q);
        if (len < 1)
            len = 1;
        if (len > LEN_LIMIT)
            len = LEN_LIMIT;
        if (int'(elem_pos) + 1 >= len)
        begin
            elem_pos = '0;
            sub_idx = (int'(sub_idx) + 1 >= MAX_SUBSPACES) ? '0 : sub_idx + 1'b1;
        end
        else
        begin
            elem_pos = elem_pos + 1'b1;
        end

        if (!lst)
            return;

        fin_clip = 1'b0;
        case (met)
            MET_DOT: fin = clip48(-run_sum, fin_clip);
            MET_COS: fin = clip48(longint'(ONE_Q16) - run_sum, fin_clip);
            MET_L2:  fin = (run_sum < 0) ? 0 : signed'(int_root(unsigned'(run_sum) << 16));
            default: fin = run_sum;
        endcase
        res.distance_val = fin[ACC_W-1:0];
        res.sat = sum_clipped | fin_clip;
        expected_distances.push_back(res);

        run_sum = 0;
        elem_pos = '0;
        sub_idx = '0;
        sum_clipped = 1'b0;
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t distance check: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Follow every beat of the three channels
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            metric_q = MET_SQL2;
            sub_len_q = SUB_LEN_RESET;
            run_sum = 0;
            elem_pos = '0;
            sub_idx = '0;
            sum_clipped = 1'b0;
            expected_distances.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_METRIC)
                    metric_q = cfg_data[2:0];
                else
                    sub_len_q = cfg_data;
            end

            if (in_valid && in_ready)
            begin
                if (operation == OP_WRITE)
                    cb_words[cb_address] = cb_value;
                else
                    accumulate_element(query_value, code, last);
            end

            // Compare the result beat with the oldest pending distance
            if (out_valid && out_ready)
            begin
                if (expected_distances.size() == 0)
                begin
                    report_mismatch("result beat with no distance pending",
                                    longint'(distance), 0);
                end
                else
                begin
                    oldest = expected_distances.pop_front();
                    if (distance !== oldest.distance_val)
                        report_mismatch("distance", longint'(distance),
                                        longint'(oldest.distance_val));
                    if (saturated !== oldest.sat)
                        report_mismatch("saturated", longint'(saturated), longint'(oldest.sat));
                end
            end

            outstanding <= expected_distances.size();
        end
    end

endmodule

[sim/tb_pq_asymmetric_distance_top.sv]
// Testbench top of the PQ asymmetric distance block: clock, reset, stimulus on the
// config and input channels, output back-pressure and the verdict.
// Depends on pqad_pkg, pq_asymmetric_distance_top and pqad_distance_checker.
`timescale 1ns / 1ps

module tb_pq_asymmetric_distance_top;

    import pqad_pkg::*;

    localparam int CLK_HALF      = 10;
    localparam int RESET_CYCLES  = 9;
    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 700;
    localparam int SUB_STRIDE    = 2048;
    localparam int CTR_STRIDE    = 8;

    localparam logic [CFG_W-1:0]  MET_UNKNOWN = 4'd7;
    localparam logic [ELEM_W-1:0] Q_MOST_NEG  = 16'h8000;
    localparam logic [ELEM_W-1:0] Q_MOST_POS  = 16'h7FFF;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic                      cfg_index;
    logic [CFG_W-1:0]          cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    logic                      operation;
    logic [ADDR_W-1:0]         cb_address;
    logic signed [ELEM_W-1:0]  cb_value;
    logic signed [ELEM_W-1:0]  query_value;
    logic [CODE_W-1:0]         code;
    logic                      last;
    logic                      out_valid;
    logic                      out_ready = 1'b0;
    logic signed [ACC_W-1:0]   distance;
    logic                      saturated;

    int  mismatches;
    int  outstanding;
    int  send_idle_pct;
    int  recv_stall_pct;
    int  cycle_count;
    int  fed_items;
    logic hold_kick = 1'b0;
    logic hold_seen = 1'b0;
    int  hold_left = 0;

    // Codebook entries loaded so far, and where the next element will read
    bit  written [CB_DEPTH];
    int  gen_pos;
    int  gen_sub;
    int  gen_len;

    always #(CLK_HALF) clk = ~clk;

    pq_asymmetric_distance_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .cb_address  (cb_address),
        .cb_value    (cb_value),
        .query_value (query_value),
        .code        (code),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .saturated   (saturated)
    );

    pqad_distance_checker distance_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .operation   (operation),
        .cb_address  (cb_address),
        .cb_value    (cb_value),
        .query_value (query_value),
        .code        (code),
        .last        (last),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .distance    (distance),
        .saturated   (saturated),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // Drive out_ready: hold off for a long stretch on request, else stall at random
    always @(posedge clk)
    begin
        if (hold_kick != hold_seen)
        begin
            hold_seen = hold_kick;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Stop a hung run
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("** pq_asymmetric_distance_top: FAILED **");
        $finish;
    end

    function automatic logic [ELEM_W-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return Q_MOST_NEG;
            1:       return Q_MOST_POS;
            2:       return '0;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic logic [ADDR_W-1:0] gen_addr(input logic [CODE_W-1:0] cd);
        logic [ADDR_W-1:0] entry;
        entry = ADDR_W'(gen_sub * SUB_STRIDE + int'(cd) * CTR_STRIDE + gen_pos);
        return entry;
    endfunction

    // Offer one input beat and hold it until accepted; valid stays high on return
    task automatic send_beat(input logic op, input logic [ADDR_W-1:0] addr,
                             input logic [ELEM_W-1:0] wval, input logic [ELEM_W-1:0] qv,
                             input logic [CODE_W-1:0] cd, input logic lst);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        operation   <= op;
        cb_address  <= addr;
        cb_value    <= wval;
        query_value <= qv;
        code        <= cd;
        last        <= lst;
        do
            @(posedge clk);
        while (!in_ready);
        fed_items++;
    endtask

    task automatic load_word(input logic [ADDR_W-1:0] addr, input logic [ELEM_W-1:0] wval);
        send_beat(OP_WRITE, addr, wval, pick_word(), 8'($urandom_range(0, 255)),
                  1'($urandom_range(0, 1)));
        written[addr] = 1'b1;
    endtask

    // Send one query element; load its codebook word first if never written
    task automatic feed_element(input logic [ELEM_W-1:0] qv, input logic [CODE_W-1:0] cd,
                                input logic lst);
        logic [ADDR_W-1:0] entry;
        entry = gen_addr(cd);
        if (!written[entry])
            load_word(entry, pick_word());
        send_beat(OP_DIST, 16'($urandom_range(0, 65535)), pick_word(), qv, cd, lst);
        if (lst)
        begin
            gen_pos = 0;
            gen_sub = 0;
        end
        else if (gen_pos + 1 >= gen_len)
        begin
            gen_pos = 0;
            gen_sub = (gen_sub + 1) % MAX_SUBSPACES;
        end
        else
        begin
            gen_pos++;
        end
    endtask

    // Drop valid and wait until every distance is back and the pipeline drains
    task automatic quiesce();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write both registers back to back while the block is idle
    task automatic set_config(input logic [CFG_W-1:0] met, input logic [CFG_W-1:0] len);
        quiesce();
        cfg_valid <= 1'b1;
        cfg_index <= CFG_METRIC;
        cfg_data  <= met;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_index <= CFG_SUB_LEN;
        cfg_data  <= len;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        gen_len = (len == 0) ? 1 : ((int'(len) > LEN_LIMIT) ? LEN_LIMIT : int'(len));
    endtask

    initial
    begin
        int                phase;
        int                phase_goal;
        int                vec_len;
        int                elem;
        logic [CODE_W-1:0] cd;
        logic [CODE_W-1:0] code_pool [4];

        rst_n       <= 1'b0;
        cfg_valid   <= 1'b0;
        cfg_index   <= CFG_METRIC;
        cfg_data    <= '0;
        in_valid    <= 1'b0;
        operation   <= OP_WRITE;
        cb_address  <= '0;
        cb_value    <= '0;
        query_value <= '0;
        code        <= '0;
        last        <= 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        gen_pos = 0;
        gen_sub = 0;
        gen_len = LEN_LIMIT;
        fed_items = 0;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: squared L2, full subspace length; extreme words and codes
        load_word(gen_addr(8'hFF), Q_MOST_NEG);
        feed_element(Q_MOST_POS, 8'hFF, 1'b0);
        load_word(gen_addr(8'h00), Q_MOST_POS);
        feed_element(Q_MOST_NEG, 8'h00, 1'b0);
        feed_element('0, 8'h3C, 1'b1);

        // Negated dot product of the two most negative words
        set_config(CFG_W'(MET_DOT), 4'd1);
        load_word(gen_addr(8'h81), Q_MOST_NEG);
        feed_element(Q_MOST_NEG, 8'h81, 1'b1);

        // Cosine, L2 root and L1, each on two elements within one subspace
        set_config(CFG_W'(MET_COS), 4'd2);
        feed_element(pick_word(), 8'h42, 1'b0);
        feed_element(Q_MOST_POS, 8'h42, 1'b1);
        set_config(CFG_W'(MET_L2), 4'd8);
        feed_element(Q_MOST_NEG, 8'h17, 1'b0);
        feed_element(Q_MOST_POS, 8'hE8, 1'b1);
        set_config(CFG_W'(MET_L1), 4'd4);
        feed_element(Q_MOST_NEG, 8'h00, 1'b0);
        feed_element(Q_MOST_POS, 8'hFF, 1'b1);

        // Unknown metric code with a zero length, then a length past the limit
        set_config(MET_UNKNOWN, 4'd0);
        feed_element(pick_word(), 8'h55, 1'b0);
        feed_element(pick_word(), 8'hAA, 1'b0);
        feed_element(pick_word(), 8'h55, 1'b1);
        set_config(CFG_W'(MET_SQL2), 4'd15);
        feed_element(pick_word(), 8'h0F, 1'b0);
        feed_element(pick_word(), 8'hF0, 1'b1);

        // Shorten the subspace under a half-fed vector, with a word load in between
        set_config(CFG_W'(MET_L1), 4'd8);
        for (elem = 0; elem < 5; elem++)
            feed_element(pick_word(), 8'h33, 1'b0);
        set_config(CFG_W'(MET_L1), 4'd3);
        feed_element(pick_word(), 8'h33, 1'b0);
        load_word(16'($urandom_range(0, 65535)), pick_word());
        feed_element(pick_word(), 8'h33, 1'b1);

        // Hold off the receiver while single-element vectors keep coming
        set_config(CFG_W'(MET_SQL2), 4'd2);
        hold_kick <= ~hold_kick;
        for (elem = 0; elem < 12; elem++)
            feed_element(pick_word(), 8'($urandom_range(0, 255)), 1'b1);
        quiesce();

        // Random vectors over four idling mixes
        fed_items = 0;
        for (phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct = 66;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 66;
                end
                default:
                begin
                    send_idle_pct = 14;
                    recv_stall_pct = 14;
                end
            endcase
            for (int i = 0; i < 4; i++)
                code_pool[i] = 8'($urandom_range(0, 255));
            phase_goal = (phase + 1) * RANDOM_ITEMS / 4;

            while (fed_items < phase_goal)
            begin
                if ($urandom_range(0, 3) == 0)
                    set_config(($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(0, 4)),
                               ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                           : 4'($urandom_range(1, 8)));
                vec_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                      : $urandom_range(1, 12);
                for (elem = 0; elem < vec_len; elem++)
                begin
                    if ($urandom_range(0, 9) == 0)
                        load_word(16'($urandom_range(0, 65535)), pick_word());
                    cd = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                                     : code_pool[$urandom_range(0, 3)];
                    feed_element(pick_word(), cd, elem == vec_len - 1);
                end
            end
            quiesce();
        end

        if (mismatches == 0)
            $display("** pq_asymmetric_distance_top: PASSED **");
        else
            $display("** pq_asymmetric_distance_top: FAILED **");
        $finish;
    end

endmodule

[pq_asymmetric_distance_top.f]
rtl/core/pqad_pkg.sv
rtl/core/pqad_ram.sv
rtl/core/pqad_front.sv
rtl/core/pqad_queue.sv
rtl/core/pqad_back.sv
rtl/core/pq_asymmetric_distance_top.sv
sim/pqad_distance_checker.sv
sim/tb_pq_asymmetric_distance_top.sv
